/* rtl/core/huffl_pkg.sv */
package huffl_pkg;

  // Fixed field widths of the code specification and the decode entries.
  localparam int NUM_LENGTHS = 16;
  localparam int KIND_W      = 2;
  localparam int SYMBOL_W    = 8;
  localparam int LEN_W       = 5;
  localparam int CODE_BITS_W = 16;
  localparam int ENTRY_W     = LEN_W + SYMBOL_W;
  localparam int QUEUE_DEPTH = 4;

  // Item kinds on the input channel.
  localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LEAF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [SYMBOL_W-1:0]    data_byte;
    logic [CODE_BITS_W-1:0] code_bits;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]    code_length;
    logic [SYMBOL_W-1:0] symbol;
    logic [LEN_W-1:0]    max_length;
  } out_item_t;

  // Commands handed from the front end to the table engine.
  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LEAF,
    CMD_LOOKUP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t                op;
    logic [LEN_W-1:0]       longest;
    logic [LEN_W-1:0]       length;
    logic [SYMBOL_W-1:0]    symbol;
    logic [CODE_BITS_W-1:0] index;
  } cmd_t;

  typedef enum logic {
    BACK_IDLE,
    BACK_FILL
  } back_state_t;

endpackage

/* rtl/core/huffl_front.sv */
module huffl_front #(
  parameter int MAX_CODE_LEN = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  huffl_pkg::in_item_t item,
  input  logic              q_full,
  output logic              push,
  output huffl_pkg::cmd_t   cmd
);

  localparam int NL = huffl_pkg::NUM_LENGTHS;
  localparam int LW = huffl_pkg::LEN_W;

  logic [huffl_pkg::SYMBOL_W-1:0] counts [NL];
  logic [LW-1:0]                  count_idx;
  logic [LW-1:0]                  longest;
  logic [LW-1:0]                  cur_len;
  logic [huffl_pkg::SYMBOL_W-1:0] left;

  logic                           accept;
  logic                           new_load;
  logic                           complete;
  logic                           leaf_ok;
  logic [huffl_pkg::SYMBOL_W-1:0] src [NL];
  logic [NL-1:0]                  nz;
  logic [NL-1:0]                  search;
  logic [3:0]                     hi_idx;
  logic                           hi_found;
  logic [3:0]                     lo_idx;
  logic                           lo_found;

  // Position of the highest set bit, as a one-hot pick then an encode.
  function automatic logic [4:0] highest(input logic [NL-1:0] m);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < NL; i++) begin
      if (m[i] && ((m >> (i + 1)) == '0)) begin
        idx = idx | 4'(i);
      end
    end
    return {|m, idx};
  endfunction

  // Position of the lowest set bit.
  function automatic logic [4:0] lowest(input logic [NL-1:0] m);
    logic [3:0] idx;
    idx = '0;
    for (int i = 0; i < NL; i++) begin
      if (m[i] && ((m & ((NL'(1) << i) - NL'(1))) == '0)) begin
        idx = idx | 4'(i);
      end
    end
    return {|m, idx};
  endfunction

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign new_load   = (count_idx == 5'd0) || (count_idx >= LW'(NL));
  assign complete   = !new_load && (count_idx == LW'(NL - 1));
  assign leaf_ok    = (count_idx == LW'(NL)) && (left != '0);

  // Counts as they stand after this transaction, for the length searches.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      src[i] = counts[i];
    end
    if (complete) begin
      src[NL-1] = item.data_byte;
    end
    for (int i = 0; i < NL; i++) begin
      nz[i] = (src[i] != '0) && (i < MAX_CODE_LEN);
    end
    search = complete ? nz : (nz & ~((NL'(1) << cur_len) - NL'(1)));
    {hi_found, hi_idx} = highest(nz);
    {lo_found, lo_idx} = lowest(search);
  end

  // Classify the item into a command for the table engine.
  always_comb begin
    push         = 1'b0;
    cmd.op       = huffl_pkg::CMD_LOOKUP;
    cmd.longest  = longest;
    cmd.length   = cur_len;
    cmd.symbol   = item.data_byte;
    cmd.index    = item.code_bits &
                   huffl_pkg::CODE_BITS_W'((17'd1 << longest) - 17'd1);
    unique case (item.kind)
      huffl_pkg::KIND_COUNT: begin
        cmd.op = huffl_pkg::CMD_CLEAR;
        push   = accept && new_load;
      end
      huffl_pkg::KIND_LEAF: begin
        cmd.op = huffl_pkg::CMD_LEAF;
        push   = accept && leaf_ok;
      end
      huffl_pkg::KIND_LOOKUP: begin
        cmd.op = huffl_pkg::CMD_LOOKUP;
        push   = accept;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  // Load state: counts, table size and the next length to place.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NL; i++) begin
        counts[i] <= '0;
      end
      count_idx <= '0;
      longest   <= '0;
      cur_len   <= LW'(1);
      left      <= '0;
    end else if (accept) begin
      unique case (item.kind)
        huffl_pkg::KIND_COUNT: begin
          if (new_load) begin
            for (int i = 1; i < NL; i++) begin
              counts[i] <= '0;
            end
            counts[0] <= item.data_byte;
            count_idx <= LW'(1);
            longest   <= '0;
            cur_len   <= LW'(1);
            left      <= '0;
          end else begin
            counts[count_idx[3:0]] <= item.data_byte;
            count_idx              <= count_idx + LW'(1);
            if (complete) begin
              longest <= hi_found ? ({1'b0, hi_idx} + LW'(1)) : '0;
              cur_len <= {1'b0, lo_idx} + LW'(1);
              left    <= lo_found ? src[lo_idx] : '0;
            end
          end
        end
        huffl_pkg::KIND_LEAF: begin
          if (leaf_ok) begin
            if (left == 8'd1) begin
              if (lo_found) begin
                cur_len <= {1'b0, lo_idx} + LW'(1);
                left    <= src[lo_idx];
              end else begin
                left <= '0;
              end
            end else begin
              left <= left - 8'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/huffl_queue.sv */
module huffl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  huffl_pkg::cmd_t push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            avail,
  output huffl_pkg::cmd_t head
);

  localparam int DEPTH = huffl_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  huffl_pkg::cmd_t    slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;
  logic               do_push;
  logic               do_pop;

  assign full    = (fill == CNT_W'(DEPTH));
  assign avail   = (fill != '0);
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  // Storage for queued commands.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

/* rtl/core/huffl_back.sv */
module huffl_back #(
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_avail,
  input  huffl_pkg::cmd_t      q_cmd,
  output logic                 q_pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output huffl_pkg::out_item_t result
);

  localparam int ADDR_W = MAX_CODE_LEN;
  localparam int CNT_W  = MAX_CODE_LEN + 1;
  localparam int DEPTH  = 1 << MAX_CODE_LEN;
  localparam int LW     = huffl_pkg::LEN_W;
  localparam int SW     = huffl_pkg::SYMBOL_W;

  logic [huffl_pkg::ENTRY_W-1:0] table_mem [DEPTH];

  huffl_pkg::back_state_t state;
  huffl_pkg::back_state_t state_next;
  logic [CNT_W-1:0]       fill_cnt;
  logic [CNT_W-1:0]       rem;
  logic [CNT_W-1:0]       limit;
  logic [LW-1:0]          fill_len;
  logic [SW-1:0]          fill_sym;

  logic [huffl_pkg::ENTRY_W-1:0] mem_q;
  logic                          a_valid;
  logic                          a_hit;
  logic [LW-1:0]                 a_longest;

  logic b_ready;
  logic a_ready;
  logic issue;
  logic wr_en;
  logic start_fill;
  logic do_clear;

  assign b_ready = !result_valid || !result_stall;
  assign a_ready = !a_valid || b_ready;

  // Command sequencing: clears, leaf fills and lookups in queue order.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    issue      = 1'b0;
    wr_en      = 1'b0;
    start_fill = 1'b0;
    do_clear   = 1'b0;
    unique case (state)
      huffl_pkg::BACK_IDLE: begin
        if (q_avail) begin
          unique case (q_cmd.op)
            huffl_pkg::CMD_CLEAR: begin
              q_pop    = 1'b1;
              do_clear = 1'b1;
            end
            huffl_pkg::CMD_LEAF: begin
              q_pop      = 1'b1;
              start_fill = 1'b1;
              state_next = huffl_pkg::BACK_FILL;
            end
            huffl_pkg::CMD_LOOKUP: begin
              q_pop = a_ready;
              issue = a_ready;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      huffl_pkg::BACK_FILL: begin
        if (fill_cnt == limit) begin
          state_next = huffl_pkg::BACK_IDLE;
        end else begin
          wr_en = 1'b1;
          if ((rem == CNT_W'(1)) || ((fill_cnt + CNT_W'(1)) == limit)) begin
            state_next = huffl_pkg::BACK_IDLE;
          end
        end
      end
      default: begin
        state_next = huffl_pkg::BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= huffl_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Fill count: entries below it hold the current load, the rest read empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_cnt <= '0;
    end else if (do_clear) begin
      fill_cnt <= '0;
    end else if (wr_en) begin
      fill_cnt <= fill_cnt + CNT_W'(1);
    end
  end

  // Span and table limit of the leaf being placed.
  always_ff @(posedge clk) begin
    if (start_fill) begin
      rem      <= CNT_W'(1) << (q_cmd.longest - q_cmd.length);
      limit    <= CNT_W'(1) << q_cmd.longest;
      fill_len <= q_cmd.length;
      fill_sym <= q_cmd.symbol;
    end else if (wr_en) begin
      rem <= rem - CNT_W'(1);
    end
  end

  // Decode table: one write port for fills, one registered read for lookups.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[fill_cnt[ADDR_W-1:0]] <= {fill_len, fill_sym};
    end
    if (issue) begin
      mem_q <= table_mem[q_cmd.index[ADDR_W-1:0]];
    end
  end

  // Read stage: the hit flag and table size travel with the read.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_hit     <= ({1'b0, q_cmd.index[ADDR_W-1:0]} < fill_cnt);
      a_longest <= q_cmd.longest;
    end
  end

  // Output register holds the transaction while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (b_ready) begin
      result_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      result.code_length <= a_hit ? mem_q[huffl_pkg::ENTRY_W-1:SW] : '0;
      result.symbol      <= a_hit ? mem_q[SW-1:0] : '0;
      result.max_length  <= a_longest;
    end
  end

endmodule

/* rtl/core/huffman_lookup_table_builder_top.sv */
// Huffman decode table builder and lookup.
// The item channel (item_valid, item_stall, item) takes count, leaf and
// lookup transactions. A load is sixteen count transactions followed by the
// leaf symbols; the first count starts a new load and empties the table.
// Each lookup returns one transaction on the result channel (result_valid,
// result_stall, result) with the code length, symbol and table size.
// Count transactions are absorbed by the front end; only the first of a
// load reaches the table engine, as a clear. A leaf occupies the table
// engine for up to 2^(max_length - length) table writes, one per cycle
// through the single write port, none once the table is full. Lookups run
// one per cycle while no leaf fill runs and result_stall is low.
// A four-entry command queue parts the front end from the table engine;
// item_stall rises only when that queue is full.
// Reset empties the table at once through a fill count, so no clearing
// pass is needed; table entries beyond the count read as unassigned.
// When result_stall is high the output transaction holds, the read stage
// and then the queue back up, and the item channel stalls.
module huffman_lookup_table_builder_top #(
  parameter int MAX_CODE_LEN = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  huffl_pkg::in_item_t  item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output huffl_pkg::out_item_t result
);

  logic            push;
  huffl_pkg::cmd_t push_cmd;
  logic            q_full;
  logic            q_pop;
  logic            q_avail;
  huffl_pkg::cmd_t q_head;

  huffl_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item      (item),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  huffl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .avail   (q_avail),
    .head    (q_head)
  );

  huffl_back #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_avail     (q_avail),
    .q_cmd       (q_head),
    .q_pop       (q_pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule
